[rtl/lps_pkg.sv]
// shared types and constants of the five-point laplacian stencil
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

    // grid width register
    localparam int CFG_BITS    = 11;
    localparam int WIDTH_RESET = 10;

    // per-word control that travels with a word into the window stage
    typedef struct packed {
        logic emit;        // word produces a result (row after the first)
        logic last;        // final result of the grid
        logic mask_left;   // first column: no left neighbor
        logic mask_right;  // last column: no right neighbor
        logic mask_up;     // first grid row: no upper neighbor
    } lps_flags_t;

endpackage

`default_nettype wire

[rtl/laplacian_5point_stencil.sv]
// top level of the streaming five-point laplacian stencil
// Takes a square grid of signed samples in raster order on the s_ channel and
// gives 4*centre - left - right - up - down for every point on the m_ channel,
// with a missing neighbor counted as zero. s_tuser high marks a flush word,
// a zero sample; after the grid, grid_width flush words drain the last row and
// the final result carries m_tlast. Words of the first grid row give no result;
// every later word gives the result for the point one row above it.
// grid_width (points per row and rows) is written through cfg_wr_en and
// cfg_wr_data; the user writes it only while the block is idle, which the block
// does not enforce. A write restarts the grid count. Throughput: one word per
// cycle while results are taken. An accepted word goes into the window stage,
// then its result into the output register. The line history sits in one ring
// memory of 2**clog2(2*MAX_WIDTH) entries with one write and two reads per word.
// A stalled receiver holds the output register; s_tready drops only while a
// result waits and the window stage holds another word that has a result.
// aresetn (synchronous) empties the pipeline, clears the row and column count
// and sets grid_width to 10; the ring needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module laplacian_5point_stencil #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     cfg_wr_en,
    input  wire logic [lps_pkg::CFG_BITS-1:0]             cfg_wr_data,  // grid_width
    input  wire logic                                     s_tvalid,
    output logic                                          s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]         s_tdata,      // sample
    input  wire logic                                     s_tuser,      // op
    output logic                                          m_tvalid,
    input  wire logic                                     m_tready,
    output logic [((SAMPLE_BITS+10)/8)*8-1:0]             m_tdata,      // lap_value
    output logic                                          m_tlast       // last
);

    import lps_pkg::*;

    localparam int NW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = SAMPLE_BITS + 3;
    localparam int OW = ((SAMPLE_BITS + 10) / 8) * 8;

    function automatic logic [NW-1:0] clamp_width(input logic [CFG_BITS-1:0] v);
        int w;
        w = int'(v);
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return NW'(w);
    endfunction

    logic [NW-1:0]                 width_reg;
    logic [NW-1:0]                 width_next;
    logic [CW-1:0]                 col_reg;
    logic [CW-1:0]                 col_next;
    logic [NW-1:0]                 row_reg;
    logic [NW-1:0]                 row_next;
    logic                          st1_valid_reg;
    logic                          st1_valid_next;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [LW-1:0]                 lap_reg;
    logic                          last_reg;

    logic                          accept;
    logic                          out_free;
    logic                          st1_adv;
    logic                          flush_row;
    logic                          last_col;
    logic signed [SAMPLE_BITS-1:0] value;
    lps_flags_t                    flags_in;
    lps_flags_t                    flags_st1;
    logic signed [SAMPLE_BITS-1:0] right_q;
    logic signed [SAMPLE_BITS-1:0] up_q;
    logic signed [LW-1:0]          lap;

    // handshake
    assign out_free = !m_valid_reg || m_tready;
    assign st1_adv  = st1_valid_reg && (out_free || !flags_st1.emit);
    assign s_tready = !st1_valid_reg || st1_adv;
    assign accept   = s_tvalid && s_tready;

    // position of the incoming word
    assign flush_row = (row_reg >= width_reg);
    assign last_col  = (NW'(col_reg) == width_reg - NW'(1));
    assign value     = (s_tuser || flush_row) ? '0 : signed'(s_tdata[SAMPLE_BITS-1:0]);

    always_comb begin
        flags_in.emit       = (row_reg != '0);
        flags_in.last       = flush_row && last_col;
        flags_in.mask_left  = (col_reg == '0);
        flags_in.mask_right = last_col;
        flags_in.mask_up    = (row_reg == NW'(1));
    end

    always_comb begin
        width_next = width_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        if (cfg_wr_en) begin
            width_next = clamp_width(cfg_wr_data);
            col_next   = '0;
            row_next   = '0;
        end else if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = flush_row ? '0 : row_reg + NW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_comb begin
        st1_valid_next = st1_valid_reg;
        if (accept) begin
            st1_valid_next = 1'b1;
        end else if (st1_adv) begin
            st1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (st1_adv && flags_st1.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= clamp_width(CFG_BITS'(WIDTH_RESET));
            col_reg       <= '0;
            row_reg       <= '0;
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            width_reg     <= width_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            st1_valid_reg <= st1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_adv && flags_st1.emit) begin
            lap_reg  <= lap;
            last_reg <= flags_st1.last;
        end
    end

    lps_ring #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (accept),
        .din     (value),
        .width   (width_reg),
        .right_q (right_q),
        .up_q    (up_q)
    );

    lps_window #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .aclk      (aclk),
        .load      (accept),
        .right_in  (right_q),
        .up_in     (up_q),
        .down_in   (value),
        .flags_in  (flags_in),
        .flags_out (flags_st1),
        .lap       (lap)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OW'(lap_reg);
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

[rtl/lps_cell.sv]
// one tap cell of the neighbor window: holds a sample, hands it on, masks it at the border
`timescale 1ns / 1ps
`default_nettype none

module lps_cell #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          load,
    input  wire logic                          kill,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic signed [SAMPLE_BITS-1:0]      sample_out,
    output logic signed [SAMPLE_BITS-1:0]      tap
);

    logic signed [SAMPLE_BITS-1:0] sample_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            sample_reg <= sample_in;
        end
    end

    assign sample_out = sample_reg;
    assign tap        = kill ? '0 : sample_reg;

endmodule

`default_nettype wire

[rtl/lps_ring.sv]
// sample delay ring: one write and two registered reads, width-1 and 2*width words back
`timescale 1ns / 1ps
`default_nettype none

module lps_ring #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  wr_en,
    input  wire logic signed [SAMPLE_BITS-1:0]         din,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]        width,
    output logic signed [SAMPLE_BITS-1:0]              right_q,
    output logic signed [SAMPLE_BITS-1:0]              up_q
);

    localparam int AW = $clog2(2 * MAX_WIDTH);

    logic [SAMPLE_BITS-1:0] mem [2**AW];
    logic [AW-1:0]          wp_reg;
    logic [AW-1:0]          wp_next;
    logic [AW-1:0]          right_addr;
    logic [AW-1:0]          up_addr;

    // right neighbor is width-1 words back, upper neighbor 2*width words back
    assign right_addr = wp_reg - AW'(width) + AW'(1);
    assign up_addr    = wp_reg - (AW'(width) << 1);
    assign wp_next    = wp_reg + AW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
        end else if (wr_en) begin
            wp_reg <= wp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wp_reg] <= din;
            right_q     <= signed'(mem[right_addr]);
            up_q        <= signed'(mem[up_addr]);
        end
    end

endmodule

`default_nettype wire

[rtl/lps_window.sv]
// neighbor window: chain of tap cells for the middle row and the stencil sum
`timescale 1ns / 1ps
`default_nettype none

module lps_window #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          load,
    input  wire logic signed [SAMPLE_BITS-1:0] right_in,
    input  wire logic signed [SAMPLE_BITS-1:0] up_in,
    input  wire logic signed [SAMPLE_BITS-1:0] down_in,
    input  wire lps_pkg::lps_flags_t           flags_in,
    output lps_pkg::lps_flags_t                flags_out,
    output logic signed [SAMPLE_BITS+2:0]      lap
);

    import lps_pkg::*;

    localparam int LW = SAMPLE_BITS + 3;

    lps_flags_t                    flags_reg;
    logic signed [SAMPLE_BITS-1:0] down_reg;
    logic signed [SAMPLE_BITS-1:0] centre_raw;
    logic signed [SAMPLE_BITS-1:0] centre_tap;
    logic signed [SAMPLE_BITS-1:0] left_raw;
    logic signed [SAMPLE_BITS-1:0] left_tap;
    logic signed [SAMPLE_BITS-1:0] right_tap;
    logic signed [SAMPLE_BITS-1:0] up_tap;
    logic signed [LW-1:0]          centre_x;
    logic signed [LW-1:0]          left_x;
    logic signed [LW-1:0]          right_x;
    logic signed [LW-1:0]          up_x;
    logic signed [LW-1:0]          down_x;

    always_ff @(posedge aclk) begin
        if (load) begin
            flags_reg <= flags_in;
            down_reg  <= down_in;
        end
    end

    // the ring output still holds the previous word's right neighbor at load,
    // which is this word's centre; the centre moves on to become the left
    lps_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_centre (
        .aclk       (aclk),
        .load       (load),
        .kill       (1'b0),
        .sample_in  (right_in),
        .sample_out (centre_raw),
        .tap        (centre_tap)
    );

    lps_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_left (
        .aclk       (aclk),
        .load       (load),
        .kill       (flags_reg.mask_left),
        .sample_in  (centre_raw),
        .sample_out (left_raw),
        .tap        (left_tap)
    );

    assign right_tap = flags_reg.mask_right ? '0 : right_in;
    assign up_tap    = flags_reg.mask_up    ? '0 : up_in;

    assign centre_x = {{3{centre_tap[SAMPLE_BITS-1]}}, centre_tap};
    assign left_x   = {{3{left_tap[SAMPLE_BITS-1]}},   left_tap};
    assign right_x  = {{3{right_tap[SAMPLE_BITS-1]}},  right_tap};
    assign up_x     = {{3{up_tap[SAMPLE_BITS-1]}},     up_tap};
    assign down_x   = {{3{down_reg[SAMPLE_BITS-1]}},   down_reg};

    assign lap       = (centre_x <<< 2) - left_x - right_x - up_x - down_x;
    assign flags_out = flags_reg;

endmodule

`default_nettype wire

[rtl/lps_check.sv]
// port checker for the laplacian stencil and its bind to the top level
`timescale 1ns / 1ps
`default_nettype none

module lps_check #(
    parameter int SAMPLE_BITS = 24
) (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_tvalid,
    input wire logic                                 s_tready,
    input wire logic                                 m_tvalid,
    input wire logic                                 m_tready,
    input wire logic [((SAMPLE_BITS+10)/8)*8-1:0]    m_tdata,
    input wire logic                                 m_tlast
);

    localparam int LW = SAMPLE_BITS + 3;

    // a stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // input side only backs up behind a stalled result
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input not ready without a stalled result");

    // padding above the result is zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >> LW) == '0)
        else $error("result padding bits not zero");

endmodule

bind laplacian_5point_stencil lps_check #(.SAMPLE_BITS(SAMPLE_BITS)) u_lps_check (.*);

`default_nettype wire

[tb/tb_laplacian_5point_stencil.sv]
// testbench for the streaming five-point laplacian stencil
`timescale 1ns / 1ps

module tb_laplacian_5point_stencil;

    localparam int MAX_W    = 1024;
    localparam int SAMPLE_W = 24;
    localparam int LAP_W    = SAMPLE_W + 3;
    localparam int S_DATA_W = ((SAMPLE_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((SAMPLE_W + 10) / 8) * 8;
    localparam int CFG_W    = lps_pkg::CFG_BITS;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    localparam logic [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum int {RX_READY, RX_LIGHT, RX_HEAVY} rx_pattern_t;

    typedef struct packed {
        logic [LAP_W-1:0] lap;
        logic             last;
    } lap_result_t;

    // mirrors the line stores and counters, queues the laplacian each word implies
    class stencil_scoreboard;
        int unsigned                grid_width;
        int unsigned                col;
        int unsigned                row;
        logic signed [SAMPLE_W-1:0] upper_row [MAX_W];
        logic signed [SAMPLE_W-1:0] middle_row [MAX_W];
        lap_result_t                lap_expected [$];
        int unsigned                failures;
        int unsigned                checked;

        function new();
            grid_width = lps_pkg::WIDTH_RESET;
            col = 0;
            row = 0;
            failures = 0;
            checked = 0;
            foreach (upper_row[i]) begin
                upper_row[i] = '0;
                middle_row[i] = '0;
            end
        endfunction

        function void write_width(logic [lps_pkg::CFG_BITS-1:0] w);
            grid_width = w;
            col = 0;
            row = 0;
        endfunction

        function void report(string what);
            failures++;
            if (failures <= 10)
                $display("mismatch %0d: %s", failures, what);
        endfunction

        function void note_sample(logic op, logic signed [SAMPLE_W-1:0] word);
            int unsigned n;
            int unsigned c;
            bit          flush_row;
            int          value;
            int          centre;
            int          up_n;
            int          left_n;
            int          right_n;
            int          lap;
            lap_result_t res;
            if (grid_width < 2)
                n = 2;
            else if (grid_width > MAX_W)
                n = MAX_W;
            else
                n = grid_width;
            c = col;
            flush_row = (row >= n);
            if (op == OP_FLUSH || flush_row)
                value = 0;
            else
                value = word;
            if (row == 0) begin
                upper_row[c] = '0;
                middle_row[c] = value[SAMPLE_W-1:0];
            end else begin
                centre = middle_row[c];
                up_n = upper_row[c];
                left_n = 0;
                right_n = 0;
                // left of the column the upper store already holds the row above
                if (c > 0)
                    left_n = upper_row[c-1];
                if (c + 1 < n)
                    right_n = middle_row[c+1];
                lap = 4 * centre - left_n - right_n - up_n - value;
                res.lap = lap[LAP_W-1:0];
                res.last = flush_row && (c == n - 1);
                lap_expected.push_back(res);
                upper_row[c] = centre[SAMPLE_W-1:0];
                middle_row[c] = value[SAMPLE_W-1:0];
            end
            if (c + 1 >= n) begin
                col = 0;
                row = flush_row ? 0 : row + 1;
            end else begin
                col = c + 1;
            end
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data, logic last);
            lap_result_t want;
            checked++;
            if (lap_expected.size() == 0) begin
                report($sformatf("result %0d with nothing expected: lap_value %0d last %0b",
                                 checked, signed'(data[LAP_W-1:0]), last));
            end else begin
                want = lap_expected.pop_front();
                if (data[LAP_W-1:0] !== want.lap || last !== want.last)
                    report($sformatf("result %0d: lap_value exp %0d got %0d, last exp %0b got %0b",
                                     checked, signed'(want.lap), signed'(data[LAP_W-1:0]),
                                     want.last, last));
            end
        endfunction

        function void flag_leftover();
            if (lap_expected.size() != 0)
                report($sformatf("%0d expected results never arrived", lap_expected.size()));
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [lps_pkg::CFG_BITS-1:0]  cfg_wr_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [S_DATA_W-1:0]           s_tdata;
    logic                          s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [M_DATA_W-1:0]           m_tdata;
    logic                          m_tlast;

    stencil_scoreboard sb;

    rx_pattern_t rx_mode;
    int          stall_left;
    int          burst_left;
    bit          gaps_on;
    int          words_sent;
    int          width_writes;
    int          grids_done;

    laplacian_5point_stencil dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),      // sample
        .s_tuser     (s_tuser),      // op
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),      // lap_value
        .m_tlast     (m_tlast)       // last
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en)
                sb.write_width(cfg_wr_data);
            if (s_tvalid && s_tready)
                sb.note_sample(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
        end
    end

    // receiver stall pattern, chosen per phase
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            m_tready = 1'b1;
            if (rx_mode == RX_LIGHT && $urandom_range(0, 99) < 10)
                stall_left = $urandom_range(1, 3);
            else if (rx_mode == RX_HEAVY && $urandom_range(0, 99) < 35)
                stall_left = $urandom_range(1, 8);
        end
    end

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 15))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return '1;
            default: return r[SAMPLE_W-1:0];
        endcase
    endfunction

    task automatic send_word(input logic op, input logic [SAMPLE_W-1:0] sample);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = sample;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        words_sent++;
    endtask

    task automatic idle_for(input int cycles);
        @(negedge aclk);
        s_tvalid = 1'b0;
        repeat (cycles - 1)
            @(negedge aclk);
    endtask

    task automatic push_word(input logic op, input logic [SAMPLE_W-1:0] sample);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
                idle_for($urandom_range(1, 6));
        end
        burst_left--;
        send_word(op, sample);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.lap_expected.size() != 0)
            @(posedge aclk);
        // first-row words give no result but may still be in flight
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_width(input logic [lps_pkg::CFG_BITS-1:0] w);
        drain_results();
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = w;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        width_writes++;
    endtask

    // raster grid plus flush row, optionally cut short or paused until drained
    task automatic send_grid(input int n, input bit noisy, input int count, input int pause_at);
        logic op;
        for (int k = 0; k < count; k++) begin
            if (k == pause_at)
                drain_results();
            op = (k / n == n) ? OP_FLUSH : OP_SAMPLE;
            if (noisy && $urandom_range(0, 9) == 0)
                op = ~op;
            push_word(op, rand_sample());
        end
        if (count == n * (n + 1))
            grids_done++;
    endtask

    initial begin
        logic [SAMPLE_W-1:0]          peak_grid [9];
        logic [SAMPLE_W-1:0]          trough_grid [9];
        logic [lps_pkg::CFG_BITS-1:0] w;
        int                           n_eff;
        int                           grids;
        int                           full_len;
        int                           stop_len;
        int                           pause_at;
        int                           random_start;
        int                           spins;
        bit                           paused_once;

        sb = new();
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_SAMPLE;
        m_tready = 1'b0;
        rx_mode = RX_READY;
        stall_left = 0;
        burst_left = 0;
        gaps_on = 1'b0;
        words_sent = 0;
        width_writes = 0;
        grids_done = 0;
        paused_once = 1'b0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // 3x3 grids: interior point at both extremes of lap_value
        peak_grid = '{S_MAX, S_MIN, '1, S_MIN, S_MAX, S_MIN, 24'h000001, S_MIN, S_MAX};
        trough_grid = '{S_MIN, S_MAX, '0, S_MAX, S_MIN, S_MAX, 24'h5A5A5A, S_MAX, S_MIN};
        write_width(CFG_W'(3));
        for (int i = 0; i < 9; i++)
            push_word(OP_SAMPLE, peak_grid[i]);
        for (int i = 0; i < 3; i++)
            push_word(OP_FLUSH, '0);
        // second grid follows without a rewrite; flush word inside the grid,
        // sample word inside the flush row
        for (int i = 0; i < 9; i++)
            push_word(i == 6 ? OP_FLUSH : OP_SAMPLE, trough_grid[i]);
        push_word(OP_FLUSH, '0);
        push_word(OP_SAMPLE, 24'h123456);
        push_word(OP_FLUSH, '0);
        grids_done += 2;

        // widths below the minimum act as 2
        rx_mode = RX_HEAVY;
        gaps_on = 1'b1;
        write_width(CFG_W'(0));
        send_grid(2, 1'b0, 6, -1);
        send_grid(2, 1'b1, 6, -1);
        write_width(CFG_W'(1));
        send_grid(2, 1'b1, 6, -1);

        // full width: a partial first row abandoned by the next write
        rx_mode = RX_LIGHT;
        gaps_on = 1'b0;
        write_width(CFG_W'(1024));
        send_grid(1024, 1'b0, 20, -1);
        // above the maximum clamps to 1024; the first row wraps into the second
        write_width('1);
        send_grid(1024, 1'b0, 1100, -1);

        random_start = words_sent;
        while (words_sent - random_start < 450) begin
            case ($urandom_range(0, 11))
                0:       w = CFG_W'($urandom_range(0, 1));
                1, 2:    w = CFG_W'($urandom_range(9, 20));
                default: w = CFG_W'($urandom_range(2, 8));
            endcase
            write_width(w);
            n_eff = (w < 2) ? 2 : w;
            gaps_on = ($urandom_range(0, 9) < 7);
            rx_mode = rx_pattern_t'($urandom_range(0, 2));
            grids = $urandom_range(1, 3);
            for (int g = 0; g < grids; g++) begin
                full_len = n_eff * (n_eff + 1);
                stop_len = full_len;
                if (g == grids - 1 && $urandom_range(0, 7) == 0)
                    stop_len = $urandom_range(1, full_len - 1);
                pause_at = -1;
                if (!paused_once && words_sent - random_start > 200) begin
                    pause_at = stop_len / 2;
                    paused_once = 1'b1;
                end
                send_grid(n_eff, ($urandom_range(0, 9) < 3), stop_len, pause_at);
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        spins = 0;
        while (sb.lap_expected.size() != 0 && spins < 10000) begin
            @(posedge aclk);
            spins++;
        end
        repeat (8) @(posedge aclk);
        sb.flag_leftover();

        $display("run covered %0d words, %0d complete grids, %0d width writes (0, 1, 2..20, 1024, 2047)",
                 words_sent, grids_done, width_writes);
        $display("%0d results checked, %0d failures", sb.checked, sb.failures);
        if (sb.failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
